[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error(msg);
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error(msg);
`else
`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, expr, msg)
`endif

`endif

[src/slcp_pkg.sv]
// ----------------------------------------------------------------------------
// slcp_pkg
// Shared types and constants of the sync/length/checksum packet link.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slcp_pkg;

    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 16;
    localparam int POS_W         = 17;
    localparam int TICK_W        = 32;
    localparam int S_TDATA_W     = 24;
    localparam int S_TUSER_W     = 3;
    localparam int M_TDATA_W     = 32;
    localparam int M_TUSER_W     = 2;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [BYTE_W-1:0] SYNC_A = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_B = 8'h55;
    // Sum of the two sync bytes.
    localparam logic [BYTE_W-1:0] SYNC_SUM = 8'hFF;
    // Sync pair plus both length/complement pairs add up to 3 * 0xFF.
    localparam logic [BYTE_W-1:0] HDR_SUM_BASE = 8'hFD;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd1000;
    localparam logic [LEN_W-1:0]  LIMIT_RESET   = 16'hFFFF;

    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEN_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        CMD_BEGIN_SEND = 3'd0,
        CMD_SEND_BYTE  = 3'd1,
        CMD_RX_BYTE    = 3'd2,
        CMD_ARM        = 3'd3,
        CMD_TICK       = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_TX_BYTE   = 2'd0,
        KIND_RX_BYTE   = 2'd1,
        KIND_RX_STATUS = 2'd2
    } out_kind_t;

    typedef enum logic [1:0] {
        RX_GOOD     = 2'd0,
        RX_BAD_SUM  = 2'd1,
        RX_OVERFLOW = 2'd2,
        RX_TIMEOUT  = 2'd3
    } rx_status_t;

    typedef enum logic [1:0] {
        JOB_ONE    = 2'd0,
        JOB_PAIR   = 2'd1,
        JOB_HEADER = 2'd2
    } job_kind_t;

    // One queued job. For a header job byte_a is the packet id, byte_b the
    // header checksum and length the payload length.
    typedef struct packed {
        job_kind_t         jkind;
        out_kind_t         okind;
        logic [BYTE_W-1:0] byte_a;
        logic [BYTE_W-1:0] byte_b;
        rx_status_t        status;
        logic [LEN_W-1:0]  length;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

[src/slcp_front.sv]
// ----------------------------------------------------------------------------
// slcp_front
// Accepts input items, keeps the transmit and receive state and turns each
// item into at most one job for the result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slcp_front (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [slcp_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire  [slcp_pkg::S_TUSER_W-1:0]      s_tuser,
    input  wire                                 cfg_valid,
    input  wire  [slcp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [slcp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  slcp_pkg::q_status_t                 q_status,
    output logic                                q_push,
    output slcp_pkg::job_t                      q_job
);
    import slcp_pkg::*;

    logic [TICK_W-1:0] timeout_reg;
    logic [LEN_W-1:0]  limit_reg;

    logic [BYTE_W-1:0] packet_id_reg, packet_id_next;
    logic [LEN_W-1:0]  tx_remaining_reg, tx_remaining_next;
    logic [BYTE_W-1:0] tx_sum_reg, tx_sum_next;
    logic              rx_armed_reg, rx_armed_next;
    logic              rx_in_frame_reg, rx_in_frame_next;
    logic [BYTE_W-1:0] rx_prev_reg, rx_prev_next;
    logic [POS_W-1:0]  rx_pos_reg, rx_pos_next;
    logic [LEN_W-1:0]  rx_length_reg, rx_length_next;
    logic [BYTE_W-1:0] rx_sum_reg, rx_sum_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    logic [BYTE_W-1:0] hdr_reg [4];

    logic              hdr_we;
    logic [1:0]        hdr_idx;
    logic              accept;
    cmd_t              cmd;
    logic [LEN_W-1:0]  slen;
    logic [BYTE_W-1:0] dbyte;
    logic [LEN_W-1:0]  hdr_len;
    logic [BYTE_W-1:0] sum_plus;
    logic [POS_W-1:0]  frame_end;

    assign s_tready  = !q_status.full;
    assign accept    = s_tvalid && s_tready;
    assign cmd       = cmd_t'(s_tuser);
    assign slen      = s_tdata[LEN_W-1:0];
    assign dbyte     = s_tdata[LEN_W +: BYTE_W];
    assign hdr_len   = {hdr_reg[0], hdr_reg[1]};
    assign sum_plus  = rx_sum_reg + dbyte;
    assign frame_end = {1'b0, rx_length_reg} + POS_W'(7);
    assign hdr_idx   = rx_pos_reg[1:0] - 2'd2;

    always_comb begin
        packet_id_next    = packet_id_reg;
        tx_remaining_next = tx_remaining_reg;
        tx_sum_next       = tx_sum_reg;
        rx_armed_next     = rx_armed_reg;
        rx_in_frame_next  = rx_in_frame_reg;
        rx_prev_next      = rx_prev_reg;
        rx_pos_next       = rx_pos_reg;
        rx_length_next    = rx_length_reg;
        rx_sum_next       = rx_sum_reg;
        elapsed_next      = elapsed_reg;
        hdr_we            = 1'b0;
        q_push            = 1'b0;
        q_job.jkind       = JOB_ONE;
        q_job.okind       = KIND_TX_BYTE;
        q_job.byte_a      = dbyte;
        q_job.byte_b      = '0;
        q_job.status      = RX_GOOD;
        q_job.length      = '0;

        if (accept) begin
            case (cmd)
                CMD_BEGIN_SEND: begin
                    packet_id_next    = packet_id_reg + 8'd1;
                    tx_sum_next       = packet_id_next + HDR_SUM_BASE;
                    tx_remaining_next = slen;
                    q_push            = 1'b1;
                    q_job.jkind       = JOB_HEADER;
                    q_job.byte_a      = packet_id_next;
                    q_job.byte_b      = tx_sum_next;
                    q_job.length      = slen;
                end
                CMD_SEND_BYTE: begin
                    if (tx_remaining_reg != '0) begin
                        tx_sum_next       = tx_sum_reg + dbyte;
                        tx_remaining_next = tx_remaining_reg - 16'd1;
                        q_push            = 1'b1;
                        q_job.byte_b      = tx_sum_next;
                        // The checksum follows the last payload byte.
                        if (tx_remaining_next == '0) begin
                            q_job.jkind = JOB_PAIR;
                        end
                    end
                end
                CMD_RX_BYTE: begin
                    if (rx_armed_reg) begin
                        rx_prev_next = dbyte;
                        if (!rx_in_frame_reg) begin
                            if (rx_prev_reg == SYNC_A && dbyte == SYNC_B) begin
                                rx_in_frame_next = 1'b1;
                                rx_pos_next      = POS_W'(2);
                                rx_sum_next      = SYNC_SUM;
                            end
                        end else if (rx_pos_reg < POS_W'(7)) begin
                            hdr_we      = (rx_pos_reg < POS_W'(6));
                            rx_sum_next = sum_plus;
                            rx_pos_next = rx_pos_reg + POS_W'(1);
                            // Packet id byte: the whole header is in hand.
                            if (rx_pos_reg == POS_W'(6)) begin
                                if (hdr_len > limit_reg) begin
                                    q_push           = 1'b1;
                                    q_job.okind      = KIND_RX_STATUS;
                                    q_job.byte_a     = '0;
                                    q_job.status     = RX_OVERFLOW;
                                    q_job.length     = hdr_len;
                                    rx_in_frame_next = 1'b0;
                                    rx_armed_next    = 1'b0;
                                end else if (hdr_len == '0 ||
                                             hdr_reg[0] != ~hdr_reg[2] ||
                                             hdr_reg[1] != ~hdr_reg[3] ||
                                             dbyte != packet_id_reg) begin
                                    rx_in_frame_next = 1'b0;
                                end else begin
                                    rx_length_next = hdr_len;
                                end
                            end
                        end else if (rx_pos_reg < frame_end) begin
                            q_push      = 1'b1;
                            q_job.okind = KIND_RX_BYTE;
                            rx_sum_next = sum_plus;
                            rx_pos_next = rx_pos_reg + POS_W'(1);
                        end else begin
                            rx_in_frame_next = 1'b0;
                            q_push           = 1'b1;
                            q_job.okind      = KIND_RX_STATUS;
                            q_job.byte_a     = '0;
                            q_job.length     = rx_length_reg;
                            if (rx_sum_reg == dbyte) begin
                                q_job.status  = RX_GOOD;
                                rx_armed_next = 1'b0;
                            end else begin
                                q_job.status = RX_BAD_SUM;
                            end
                        end
                    end
                end
                CMD_ARM: begin
                    rx_armed_next    = 1'b1;
                    rx_in_frame_next = 1'b0;
                    rx_prev_next     = '0;
                    rx_pos_next      = '0;
                    rx_length_next   = '0;
                    rx_sum_next      = '0;
                    elapsed_next     = '0;
                end
                CMD_TICK: begin
                    if (rx_armed_reg) begin
                        if (elapsed_reg != '1) begin
                            elapsed_next = elapsed_reg + 32'd1;
                        end
                        if (elapsed_next > timeout_reg) begin
                            q_push           = 1'b1;
                            q_job.okind      = KIND_RX_STATUS;
                            q_job.byte_a     = '0;
                            q_job.status     = RX_TIMEOUT;
                            rx_armed_next    = 1'b0;
                            rx_in_frame_next = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg      <= TIMEOUT_RESET;
            limit_reg        <= LIMIT_RESET;
            packet_id_reg    <= '0;
            tx_remaining_reg <= '0;
            tx_sum_reg       <= '0;
            rx_armed_reg     <= 1'b0;
            rx_in_frame_reg  <= 1'b0;
            rx_prev_reg      <= '0;
            rx_pos_reg       <= '0;
            rx_length_reg    <= '0;
            rx_sum_reg       <= '0;
            elapsed_reg      <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_TIMEOUT:   timeout_reg <= cfg_data[TICK_W-1:0];
                    CFG_LEN_LIMIT: limit_reg   <= cfg_data[LEN_W-1:0];
                    default: begin
                    end
                endcase
            end
            packet_id_reg    <= packet_id_next;
            tx_remaining_reg <= tx_remaining_next;
            tx_sum_reg       <= tx_sum_next;
            rx_armed_reg     <= rx_armed_next;
            rx_in_frame_reg  <= rx_in_frame_next;
            rx_prev_reg      <= rx_prev_next;
            rx_pos_reg       <= rx_pos_next;
            rx_length_reg    <= rx_length_next;
            rx_sum_reg       <= rx_sum_next;
            elapsed_reg      <= elapsed_next;
        end
    end

    // Header bytes are always written within a frame before they are read.
    always_ff @(posedge aclk) begin
        if (hdr_we) begin
            hdr_reg[hdr_idx] <= dbyte;
        end
    end

endmodule

`default_nettype wire

[src/slcp_queue.sv]
// ----------------------------------------------------------------------------
// slcp_queue
// Short job queue between the front and the back of the packet link.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slcp_queue #(
    parameter int DEPTH = slcp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  push,
    input  slcp_pkg::job_t       push_job,
    input  wire                  pop,
    output slcp_pkg::job_t       head_job,
    output slcp_pkg::q_status_t  status
);
    import slcp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

[src/slcp_back.sv]
// ----------------------------------------------------------------------------
// slcp_back
// Expands queued jobs into result items, one per cycle unless m_tready stalls
// them, through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slcp_back (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  slcp_pkg::job_t                   head_job,
    input  slcp_pkg::q_status_t              q_status,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [slcp_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [slcp_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                             m_tlast
);
    import slcp_pkg::*;

    // Positions within a transmitted header.
    localparam logic [2:0] ST_SYNC_A  = 3'd0;
    localparam logic [2:0] ST_SYNC_B  = 3'd1;
    localparam logic [2:0] ST_LEN_HI  = 3'd2;
    localparam logic [2:0] ST_LEN_LO  = 3'd3;
    localparam logic [2:0] ST_NLEN_HI = 3'd4;
    localparam logic [2:0] ST_NLEN_LO = 3'd5;
    localparam logic [2:0] ST_ID      = 3'd6;

    logic [2:0]        step_reg;
    logic              valid_reg;
    out_kind_t         kind_reg;
    logic [BYTE_W-1:0] byte_reg;
    rx_status_t        status_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              last_reg;

    logic              load;
    logic [BYTE_W-1:0] cur_byte;
    logic              cur_last;

    assign load  = !q_status.empty && (!valid_reg || m_tready);
    assign q_pop = load && cur_last;

    always_comb begin
        cur_byte = head_job.byte_a;
        cur_last = 1'b1;
        case (head_job.jkind)
            JOB_PAIR: begin
                cur_last = (step_reg != '0);
                cur_byte = cur_last ? head_job.byte_b : head_job.byte_a;
            end
            JOB_HEADER: begin
                cur_last = 1'b0;
                case (step_reg)
                    ST_SYNC_A:  cur_byte = SYNC_A;
                    ST_SYNC_B:  cur_byte = SYNC_B;
                    ST_LEN_HI:  cur_byte = head_job.length[LEN_W-1 -: BYTE_W];
                    ST_LEN_LO:  cur_byte = head_job.length[BYTE_W-1:0];
                    ST_NLEN_HI: cur_byte = ~head_job.length[LEN_W-1 -: BYTE_W];
                    ST_NLEN_LO: cur_byte = ~head_job.length[BYTE_W-1:0];
                    ST_ID: begin
                        cur_byte = head_job.byte_a;
                        cur_last = (head_job.length != '0);
                    end
                    default: begin
                        // Checksum right after the header of an empty packet.
                        cur_byte = head_job.byte_b;
                        cur_last = 1'b1;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            step_reg  <= cur_last ? '0 : step_reg + 3'd1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg   <= (head_job.jkind == JOB_ONE) ? head_job.okind : KIND_TX_BYTE;
            byte_reg   <= cur_byte;
            status_reg <= head_job.status;
            len_reg    <= (head_job.jkind == JOB_ONE) ? head_job.length : '0;
            last_reg   <= cur_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {(M_TDATA_W - LEN_W - 2 - BYTE_W)'(0), len_reg, status_reg, byte_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

[src/sync_length_checksum_packet_link.sv]
// ----------------------------------------------------------------------------
// sync_length_checksum_packet_link
// Packet framer and deframer: sync AA 55, length, complemented length,
// packet id, payload and an 8-bit additive checksum.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake          Contents
//  s_        in   s_tvalid/s_tready  tuser cmd; tdata send_length, data_byte
//  m_        out  m_tvalid/m_tready  tuser out_kind; tdata byte, status, length
//  cfg_      in   cfg_valid/cfg_ready register index and write data
//
//  An input item is taken in the cycle it arrives while the job queue has room.
//  Most items yield at most one result; begin_send yields 7 or 8 line bytes,
//  produced one per cycle by the back part while m_tready does not stall it.
//  The job queue (QUEUE_DEPTH jobs) lets the front run ahead of the output.
//  aresetn is synchronous and active low; no clearing pass follows reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sync_length_checksum_packet_link #(
    parameter int QUEUE_DEPTH = slcp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [slcp_pkg::S_TDATA_W-1:0]      s_tdata,   // send_length, data_byte
    input  wire  [slcp_pkg::S_TUSER_W-1:0]      s_tuser,   // cmd
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [slcp_pkg::M_TDATA_W-1:0]      m_tdata,   // out_byte, rx_status,
                                                           // frame_length, zero pad
    output logic [slcp_pkg::M_TUSER_W-1:0]      m_tuser,   // out_kind
    output logic                                m_tlast,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [slcp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [slcp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import slcp_pkg::*;

    q_status_t q_status;
    logic      q_push;
    logic      q_pop;
    job_t      push_job;
    job_t      head_job;

    assign cfg_ready = 1'b1;

    slcp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    slcp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .status   (q_status)
    );

    slcp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_status (q_status),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `ASSERT_NEVER(a_no_push_when_full, aclk, aresetn, q_push && q_status.full, "job pushed into full queue")
    `ASSERT_NEVER(a_no_pop_when_empty, aclk, aresetn, q_pop && q_status.empty, "job popped from empty queue")
    `ASSERT_CLK(a_status_no_byte, aclk, aresetn, (m_tvalid && m_tuser == KIND_RX_STATUS) |-> (m_tdata[7:0] == 8'd0 && m_tlast), "status item carries a byte or is not last")
    `ASSERT_CLK(a_byte_no_status, aclk, aresetn, (m_tvalid && m_tuser != KIND_RX_STATUS) |-> (m_tdata[25:8] == 18'd0), "byte item carries status or length")

endmodule

`default_nettype wire
